[design/bcfq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcfq_pkg
// Shared types and constants for the bracket command frame queue: character
// codes, command codes, queue geometry and the push record from the parser.
// ----------------------------------------------------------------------------
package bcfq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [7:0] CHAR_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_SIX   = 8'h36;

   localparam logic [2:0] CODE_WAIT  = 3'd6;
   localparam logic [2:0] CODE_ERROR = 3'd7;

   localparam logic [2:0] VALUE_NONE = 3'd0;
   localparam logic [2:0] VALUE_WAIT = 3'd7;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   typedef enum logic [2:0] {
      PH_HEAD = 3'b001,
      PH_NUM  = 3'b010,
      PH_TAIL = 3'b100
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] value;
   } push_type;

   typedef logic [PTR_W-1:0] ptr_type;

endpackage : bcfq_pkg
`default_nettype wire

[design/bcfq_frame_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcfq_frame_parser
// Frame machine for '[' digit ']' frames. Emits a push record for each
// accepted digit '1'..'6' found in the number phase.
// ----------------------------------------------------------------------------
module bcfq_frame_parser
   import bcfq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_valid,
   input  wire logic [7:0] byte_data,
   output push_type        push
);

   phase_type  phase_ff;
   phase_type  phase_in;
   logic [2:0] digit_full;
   logic       is_digit;

   assign digit_full = byte_data[2:0] - CHAR_ZERO[2:0];
   assign is_digit   = (byte_data >= CHAR_ONE) && (byte_data <= CHAR_SIX);

   always_comb begin
      phase_in   = phase_ff;
      push.valid = 1'b0;
      push.value = digit_full;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HEAD: begin
               if (byte_data == CHAR_OPEN) phase_in = PH_NUM;
            end
            PH_NUM: begin
               if (is_digit) begin
                  push.valid = 1'b1;
                  phase_in   = PH_TAIL;
               end else if (byte_data == CHAR_OPEN) begin
                  phase_in = PH_NUM;
               end else begin
                  phase_in = PH_HEAD;
               end
            end
            PH_TAIL: begin
               if (byte_data == CHAR_OPEN) phase_in = PH_NUM;
               else if (byte_data == CHAR_CLOSE) phase_in = PH_HEAD;
               else phase_in = PH_HEAD;
            end
            default: phase_in = PH_HEAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule : bcfq_frame_parser
`default_nettype wire

[design/bracket_command_frame_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_command_frame_queue
// Parses '[' digit ']' command frames into a ring queue and answers polls
// with the latched command code.
// ----------------------------------------------------------------------------
// One request transfer is taken every cycle: a received byte (req_tuser 0)
// or a poll (req_tuser 1). Each request sits in an input register, where
// the frame machine, the queue push or pop and the held command update are
// done in a single pass; a poll then loads one response into the output
// register, from which its response transfer is made. Bytes give no
// response. The rate is set by that single-pass update of the queue
// pointers and held command; the output register lets requests keep
// flowing while a response waits, and only a poll behind a stalled
// response waits, holding the requests behind it. The queue holds
// QUEUE_DEPTH-1 commands; a digit arriving when it is full is dropped.
// ----------------------------------------------------------------------------
module bracket_command_frame_queue
   import bcfq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   input  wire logic [0:0] req_tuser,   // [0] command
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [2:0] command_code, [7:3] zero
   output logic [0:0]      rsp_tuser    // [0] queue_was_empty
);

   logic       in_valid_ff;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       advance;

   logic       out_valid_ff;
   logic       out_valid_in;
   logic [2:0] out_code_ff;
   logic [2:0] out_code_in;
   logic       out_empty_ff;
   logic       out_empty_in;

   logic [2:0] queue_store [QUEUE_DEPTH];
   ptr_type    wr_ptr_ff;
   ptr_type    wr_ptr_in;
   ptr_type    rd_ptr_ff;
   ptr_type    rd_ptr_in;
   ptr_type    wr_next;
   ptr_type    rd_next;
   logic [2:0] held_ff;
   logic [2:0] held_in;
   logic [2:0] pop_value;

   logic       is_poll;
   logic       queue_empty;
   push_type   push;

   function automatic ptr_type next_slot(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + ptr_type'(1);
      return r;
   endfunction

   assign is_poll    = in_valid_ff && (in_cmd_ff == REQ_POLL);
   assign advance    = !is_poll || !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   bcfq_frame_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (in_valid_ff && (in_cmd_ff == REQ_BYTE)),
      .byte_data  (in_byte_ff),
      .push       (push)
   );

   assign wr_next     = next_slot(wr_ptr_ff);
   assign rd_next     = next_slot(rd_ptr_ff);
   assign queue_empty = (rd_ptr_ff == wr_ptr_ff);
   assign pop_value   = queue_store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      held_in      = held_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_code_in  = out_code_ff;
      out_empty_in = out_empty_ff;
      if (push.valid && (wr_next != rd_ptr_ff)) wr_ptr_in = wr_next;
      if (is_poll && advance) begin
         out_valid_in = 1'b1;
         out_empty_in = queue_empty;
         if (queue_empty) begin
            out_code_in = held_ff;
         end else begin
            rd_ptr_in = rd_next;
            case (pop_value)
               VALUE_NONE: out_code_in = held_ff;
               3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6: begin
                  held_in     = pop_value - 3'd1;
                  out_code_in = held_in;
               end
               VALUE_WAIT: begin
                  held_in     = CODE_WAIT;
                  out_code_in = CODE_WAIT;
               end
               default: out_code_in = CODE_ERROR;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid && (wr_next != rd_ptr_ff)) queue_store[wr_ptr_ff] <= push.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         held_ff      <= CODE_WAIT;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         out_valid_ff <= out_valid_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_cmd_ff  <= req_tuser[0];
         in_byte_ff <= req_tdata;
      end
      out_code_ff  <= out_code_in;
      out_empty_ff <= out_empty_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_code_ff};
   assign rsp_tuser  = out_empty_ff;

endmodule : bracket_command_frame_queue
`default_nettype wire

[design/bcfq_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcfq_checker
// Port-level checks on the bracket command frame queue, bound to the top.
// ----------------------------------------------------------------------------
module bcfq_checker
   import bcfq_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] req_tdata,
   input wire logic [0:0] req_tuser,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [0:0] rsp_tuser
);

   logic req_transfer;

   assign req_transfer = req_tvalid && req_tready && (req_tdata == req_tdata)
                         && (req_tuser == req_tuser);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response present after reset");

   a_no_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] != CODE_ERROR) && (rsp_tdata[7:3] == 5'b0))
      else $error("unreachable command code reported");

   a_ready_when_drained: assert property (@(posedge clock)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   a_poll_reply: assert property (@(posedge clock) disable iff (reset)
      req_transfer && req_tuser[0] && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("poll produced no response");

endmodule : bcfq_checker

bind bracket_command_frame_queue bcfq_checker u_checker (.*);
`default_nettype wire
